### hdl/smax_pkg.sv
// shared types, constants and exponent tables for the softmax/argmax core
package smax_pkg;

   typedef struct packed {
      logic signed [15:0] logit;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [3:0]  class_index;
      logic [16:0] probability;
      logic [3:0]  best_index;
      logic [16:0] best_probability;
      logic        dropped;
      logic        final_res;
   } rsp_type;

   // exp(-n), n = 0..11, Q1.16
   function automatic logic [16:0] exp_int(input logic [3:0] n);
      logic [16:0] r;
      case (n)
         4'd0: r = 17'd65536;
         4'd1: r = 17'd24109;
         4'd2: r = 17'd8869;
         4'd3: r = 17'd3263;
         4'd4: r = 17'd1200;
         4'd5: r = 17'd442;
         4'd6: r = 17'd162;
         4'd7: r = 17'd60;
         4'd8: r = 17'd22;
         4'd9: r = 17'd8;
         4'd10: r = 17'd3;
         4'd11: r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // exp(-h/16), Q1.16
   function automatic logic [16:0] exp_hi(input logic [3:0] h);
      logic [16:0] r;
      case (h)
         4'd0: r = 17'd65536;  4'd1: r = 17'd61565;
         4'd2: r = 17'd57835;  4'd3: r = 17'd54331;
         4'd4: r = 17'd51039;  4'd5: r = 17'd47947;
         4'd6: r = 17'd45041;  4'd7: r = 17'd42312;
         4'd8: r = 17'd39750;  4'd9: r = 17'd37341;
         4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
         4'd12: r = 17'd30957; 4'd13: r = 17'd29081;
         4'd14: r = 17'd27319; default: r = 17'd25664;
      endcase
      return r;
   endfunction

   // exp(-l/256), Q1.16
   function automatic logic [16:0] exp_lo(input logic [3:0] l);
      logic [16:0] r;
      case (l)
         4'd0: r = 17'd65536;  4'd1: r = 17'd65280;
         4'd2: r = 17'd65026;  4'd3: r = 17'd64772;
         4'd4: r = 17'd64520;  4'd5: r = 17'd64268;
         4'd6: r = 17'd64018;  4'd7: r = 17'd63768;
         4'd8: r = 17'd63520;  4'd9: r = 17'd63272;
         4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
         4'd12: r = 17'd62535; 4'd13: r = 17'd62291;
         4'd14: r = 17'd62048; default: r = 17'd61806;
      endcase
      return r;
   endfunction

endpackage

### hdl/smax_exp.sv
// two-stage table exponent: e = exp(-d) in Q1.16, d in Q8.8
module smax_exp
   import smax_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] diff,
   output logic [16:0] expo
);
   logic [16:0] part_ff, part_in;
   logic [3:0]  lo_ff;
   logic        zero_ff;
   logic [33:0] prod_a, prod_b;

   // stage one: integer part times high fraction
   assign prod_a  = exp_int(diff[11:8]) * exp_hi(diff[7:4]) + 34'd32768;
   assign part_in = prod_a[32:16];

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      lo_ff   <= diff[3:0];
      zero_ff <= (diff[15:8] >= 8'd12);
   end

   // stage two: times low fraction
   assign prod_b = part_ff * exp_lo(lo_ff) + 34'd32768;
   assign expo   = zero_ff ? 17'd0 : prod_b[32:16];
endmodule

### hdl/smax_div.sv
// restoring divider: quo = floor((num * 65536 + den/2) / den), one bit a cycle
module smax_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [16:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [16:0] quo
);
   localparam int Nb = 34;
   logic [33:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_in;
   logic [32:0] trial;
   logic [33:0] start_val;

   assign start_val = {num, 16'd0} + {3'd0, den[31:1]};
   assign trial     = {rem_ff[31:0], dvd_ff[33]};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         dvd_in = start_val;
         rem_in = '0;
         cnt_in = 6'(Nb);
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift in next dividend bit and trial-subtract
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            dvd_in = {dvd_ff[32:0], 1'b1};
         end else begin
            rem_in = trial;
            dvd_in = {dvd_ff[32:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done   <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (go) den_ff <= den;
   end

   assign quo = (den_ff == 32'd0) ? 17'd0 : dvd_ff[16:0];
endmodule

### hdl/softmax_argmax_classifier_core.sv
// top level: logit store, exponent pass, division pass and result emission
// each probability is a read of its stored exponent followed by a run of the bit-serial divider
// after the last beat busy stays high until the final result; result beats alternate with S_EMIT states
// synchronous reset clears set state; the logit memory is not cleared
// results carry a strobe and cannot be held off by the receiver
module softmax_argmax_classifier_core
   import smax_pkg::*;
#(
   parameter int MAX_CLASSES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_CLASSES);
   localparam int CW = $clog2(MAX_CLASSES + 1);

   typedef enum logic [5:0] {
      S_LOAD = 6'b000001,
      S_EXP  = 6'b000010,
      S_DIV  = 6'b000100,
      S_DWT  = 6'b001000,
      S_EMIT = 6'b010000,
      S_EWT  = 6'b100000
   } state_type;

   state_type st_ff, st_in;

   // logit and exponent memories
   logic signed [15:0] lmem [MAX_CLASSES];
   logic [16:0]        emem [MAX_CLASSES];
   logic signed [15:0] lrd_ff;
   logic [16:0]        erd_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic signed [15:0] max_ff, max_in;
   logic [31:0]   sum_ff, sum_in;
   logic [CW-1:0] idx_ff, idx_in;   // read pointer
   logic [CW:0]   pipe_ff, pipe_in; // exponent write count; bit 0 flags a running division
   logic [1:0]    vld_ff, vld_in;   // exponent pipe valid
   logic [AW-1:0] widx [3];
   logic [AW-1:0] bidx_ff, bidx_in;
   logic [16:0]   bprob_ff, bprob_in;

   logic          accept;
   logic [15:0]   diff;
   logic [16:0]   expo;
   logic          div_go, div_done;
   logic [16:0]   quo;

   assign busy   = (st_ff != S_LOAD);
   assign accept = start && !busy;
   assign diff   = 16'(max_ff - lrd_ff);

   smax_exp u_exp (.clock(clock), .diff(diff), .expo(expo));
   smax_div u_div (.clock(clock), .reset(reset), .go(div_go), .num(erd_ff),
                   .den(sum_ff), .done(div_done), .quo(quo));

   // memory ports
   always_ff @(posedge clock) begin
      if (accept && cnt_ff < CW'(MAX_CLASSES)) lmem[cnt_ff[AW-1:0]] <= req_data.logit;
      lrd_ff <= lmem[idx_ff[AW-1:0]];
      // exponents land first, probabilities then overwrite them entry by entry
      if (vld_ff[1]) emem[widx[2]] <= expo;
      else if (div_done) emem[widx[0]] <= quo;
      erd_ff <= emem[idx_ff[AW-1:0]];
   end

   // index pipe for exponent writeback (read, lrd, expo) and the entry index for division writeback
   always_ff @(posedge clock) begin
      widx[1] <= idx_ff[AW-1:0];
      widx[2] <= widx[1];
      if (st_ff == S_DIV) widx[0] <= idx_ff[AW-1:0];
   end

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      pipe_in  = pipe_ff;
      vld_in   = {vld_ff[0], 1'b0};
      bidx_in  = bidx_ff;
      bprob_in = bprob_ff;
      div_go   = 1'b0;
      unique case (st_ff)
         S_LOAD: begin
            if (accept) begin
               if (cnt_ff < CW'(MAX_CLASSES)) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (req_data.logit > max_ff) max_in = req_data.logit;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  st_in   = S_EXP;
                  idx_in  = '0;
                  pipe_in = '0;
                  sum_in  = '0;
               end
            end
         end
         S_EXP: begin
            // issue reads, accumulate exponents as they emerge
            if (idx_ff < cnt_ff) begin
               vld_in[0] = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
            if (vld_ff[1]) begin
               sum_in  = sum_ff + 32'(expo);
               pipe_in = pipe_ff + 1'b1;
            end
            if (vld_ff[1] && pipe_ff + 1'b1 == {1'b0, cnt_ff}) begin
               st_in    = S_DIV;
               idx_in   = '0;
               pipe_in  = '0;
               bidx_in  = '0;
               bprob_in = '0;
            end
         end
         S_DIV: begin
            // erd_ff is loaded with entry idx here and holds it in S_DWT
            st_in = S_DWT;
         end
         S_DWT: begin
            if (pipe_ff[0] == 1'b0) begin
               div_go  = 1'b1;
               pipe_in[0] = 1'b1;
            end else if (div_done) begin
               if (quo > bprob_ff || idx_ff == '0) begin
                  bprob_in = quo;
                  bidx_in  = idx_ff[AW-1:0];
               end
               pipe_in[0] = 1'b0;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == cnt_ff) begin
                  st_in  = S_EMIT;
                  idx_in = '0;
               end else begin
                  st_in = S_DIV;
               end
            end
         end
         S_EMIT: st_in = S_EWT;
         S_EWT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == cnt_ff) begin
               st_in  = S_LOAD;
               cnt_in = '0;
               ovf_in = 1'b0;
               max_in = 16'sh8000;
               sum_in = '0;
            end else begin
               st_in = S_EMIT;
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_LOAD;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         max_ff  <= 16'sh8000;
         sum_ff  <= '0;
         idx_ff  <= '0;
         pipe_ff <= '0;
         vld_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         idx_ff  <= idx_in;
         pipe_ff <= pipe_in;
         vld_ff  <= vld_in;
      end
      bidx_ff  <= bidx_in;
      bprob_ff <= bprob_in;
   end

   // result beat
   assign rsp_valid                 = (st_ff == S_EWT);
   assign rsp_data.class_index      = 4'(idx_ff);
   assign rsp_data.probability      = erd_ff;
   assign rsp_data.best_index       = 4'(bidx_ff);
   assign rsp_data.best_probability = bprob_ff;
   assign rsp_data.dropped          = ovf_ff;
   assign rsp_data.final_res        = (idx_ff + 1'b1 == cnt_ff);

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_CLASSES)) else $error("class count overrun");
   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_res |=> !busy) else $error("set did not close");
endmodule
